// ----- rtl/ccr_pkg.sv -----
// Package for the clock-control register bank: word indexes, constants and decode functions.
`timescale 1ns / 1ps

package ccr_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned FREQ_W = 27;
	localparam int unsigned IDX_W  = 3;

	// Word indexes (byte offset divided by four)
	localparam logic [IDX_W-1:0] IDX_CONTROL   = 3'd0;
	localparam logic [IDX_W-1:0] IDX_CONFIG    = 3'd1;
	localparam logic [IDX_W-1:0] IDX_IRQ       = 3'd2;
	localparam logic [IDX_W-1:0] IDX_PRST      = 3'd3;
	localparam logic [IDX_W-1:0] IDX_UNMAPPED  = 3'd4;
	localparam logic [IDX_W-1:0] IDX_FAST_EN   = 3'd5;
	localparam logic [IDX_W-1:0] IDX_HIGH_EN   = 3'd6;
	localparam logic [IDX_W-1:0] IDX_LOW_EN    = 3'd7;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Switch status codes
	localparam logic [1:0] SW_PLL = 2'd2;

	localparam logic [DATA_W-1:0] CONTROL_RESET = 32'h0000_0003;

	localparam logic [22:0] HZ_8M = 23'd8000000;
	localparam logic [22:0] HZ_4M = 23'd4000000;
	localparam logic [3:0]  PLL_MUL_MAX_CODE = 4'hF;
	localparam logic [4:0]  PLL_MUL_MAX = 5'd16;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [FREQ_W-1:0] freq_t;

	// Ready bits 1, 17 and 25 follow the enables at bits 0, 16 and 24.
	function automatic word_t mirror_control(input word_t w);
		word_t r;
		r     = w;
		r[1]  = w[0];
		r[17] = w[16];
		r[25] = w[24];
		return r;
	endfunction

	// Switch status (bits 3:2) follows the switch field (bits 1:0).
	function automatic word_t mirror_config(input word_t w);
		word_t r;
		r      = w;
		r[3:2] = w[1:0];
		return r;
	endfunction

	function automatic logic [3:0] ahb_shift(input logic [3:0] code);
		logic [3:0] s;
		unique case (code)
			4'd8:    s = 4'd1;
			4'd9:    s = 4'd2;
			4'd10:   s = 4'd3;
			4'd11:   s = 4'd4;
			4'd12:   s = 4'd6;
			4'd13:   s = 4'd7;
			4'd14:   s = 4'd8;
			4'd15:   s = 4'd9;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

	function automatic logic [2:0] apb_shift(input logic [2:0] code);
		logic [2:0] s;
		unique case (code)
			3'd4:    s = 3'd1;
			3'd5:    s = 3'd2;
			3'd6:    s = 3'd3;
			3'd7:    s = 3'd4;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/clock_control_register_block.sv -----
// Clock-control register bank: bus word accesses with derived clock frequencies.
// Each accepted access item has its result item registered in the output register.
// Throughput: one item per cycle; input is taken whenever the output register is empty
// or being drained in the same cycle, so the single output register sets the rate.
// Reset (arst_n low, asynchronous): control word 0x3, all other words zero, no result pending.
`timescale 1ns / 1ps

module clock_control_register_block (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] write_data
	input  logic [3:0]   s_tuser,   // [0] opcode, [3:1] reg_index
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata    // [31:0] read_data, [58:32] sysclk_hz, [85:59] hclk_hz,
	                                // [112:86] pclk1_hz, [139:113] pclk2_hz, [143:140] zero
);

	// Register bank. Control and config words are always stored with their
	// status bits already mirrored, so reads need no further fix-up.
	ccr_pkg::word_t control_q, config_q, irq_q, prst_q, fast_en_q, high_en_q, low_en_q;

	// Output register
	logic           out_valid_q;
	ccr_pkg::word_t rd_q;
	ccr_pkg::freq_t sys_q, hclk_q, pclk1_q, pclk2_q;

	logic                        accept;
	logic                        wr;
	logic [ccr_pkg::IDX_W-1:0]   idx;
	ccr_pkg::word_t              wdata;
	ccr_pkg::word_t              control_d, config_d, irq_d, prst_d;
	ccr_pkg::word_t              fast_en_d, high_en_d, low_en_d;
	ccr_pkg::word_t              rd_d;

	ccr_pkg::word_t              cfg_now;
	logic [22:0]                 pll_in;
	logic [4:0]                  pll_mul;
	logic [27:0]                 pll_hz;
	ccr_pkg::freq_t              sys_d, hclk_d, pclk1_d, pclk2_d;

	// The output register frees itself when the sink takes the pending item.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign wr    = (s_tuser[0] == ccr_pkg::OP_WRITE);
	assign idx   = s_tuser[3:1];
	assign wdata = s_tdata;

	// Register update and read data for this access.
	always_comb begin
		control_d = control_q;
		config_d  = config_q;
		irq_d     = irq_q;
		prst_d    = prst_q;
		fast_en_d = fast_en_q;
		high_en_d = high_en_q;
		low_en_d  = low_en_q;
		rd_d      = '0;
		unique case (idx)
			ccr_pkg::IDX_CONTROL: begin
				if (wr) begin
					control_d = ccr_pkg::mirror_control(wdata);
				end
				rd_d = control_d;
			end
			ccr_pkg::IDX_CONFIG: begin
				if (wr) begin
					config_d = ccr_pkg::mirror_config(wdata);
				end
				rd_d = config_d;
			end
			ccr_pkg::IDX_IRQ: begin
				if (wr) begin
					irq_d = wdata;
				end
				rd_d = irq_d;
			end
			ccr_pkg::IDX_PRST: begin
				// Holds what was written; it does not clear itself.
				if (wr) begin
					prst_d = wdata;
				end
				rd_d = prst_d;
			end
			ccr_pkg::IDX_FAST_EN: begin
				if (wr) begin
					fast_en_d = wdata;
				end
				rd_d = fast_en_d;
			end
			ccr_pkg::IDX_HIGH_EN: begin
				if (wr) begin
					high_en_d = wdata;
				end
				rd_d = high_en_d;
			end
			ccr_pkg::IDX_LOW_EN: begin
				if (wr) begin
					low_en_d = wdata;
				end
				rd_d = low_en_d;
			end
			default: begin
				// Unmapped word: writes are dropped and it reads as zero.
				rd_d = '0;
			end
		endcase
	end

	// Frequencies follow the configuration word as it stands after the access.
	assign cfg_now = config_d;

	always_comb begin
		pll_in  = cfg_now[16] ? ccr_pkg::HZ_8M : ccr_pkg::HZ_4M;
		pll_mul = (cfg_now[21:18] == ccr_pkg::PLL_MUL_MAX_CODE) ? ccr_pkg::PLL_MUL_MAX
		                                                        : {1'b0, cfg_now[21:18]} + 5'd2;
		pll_hz  = 28'(pll_in) * 28'(pll_mul);
		if (cfg_now[3:2] == ccr_pkg::SW_PLL) begin
			sys_d = pll_hz[ccr_pkg::FREQ_W-1:0];
		end else begin
			sys_d = ccr_pkg::FREQ_W'(ccr_pkg::HZ_8M);
		end
		hclk_d  = sys_d >> ccr_pkg::ahb_shift(cfg_now[7:4]);
		pclk1_d = hclk_d >> ccr_pkg::apb_shift(cfg_now[10:8]);
		pclk2_d = hclk_d >> ccr_pkg::apb_shift(cfg_now[13:11]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= ccr_pkg::CONTROL_RESET;
			config_q  <= '0;
			irq_q     <= '0;
			prst_q    <= '0;
			fast_en_q <= '0;
			high_en_q <= '0;
			low_en_q  <= '0;
		end else if (accept) begin
			control_q <= control_d;
			config_q  <= config_d;
			irq_q     <= irq_d;
			prst_q    <= prst_d;
			fast_en_q <= fast_en_d;
			high_en_q <= high_en_d;
			low_en_q  <= low_en_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload carries no reset; it is only looked at while valid.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q    <= rd_d;
			sys_q   <= sys_d;
			hclk_q  <= hclk_d;
			pclk1_q <= pclk1_d;
			pclk2_q <= pclk2_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, pclk2_q, pclk1_q, hclk_q, sys_q, rd_q};

`ifndef NO_ASSERTIONS
	// Ready bits in the stored control word always track their enables.
	a_ctrl_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		(control_q[1] == control_q[0]) && (control_q[17] == control_q[16])
		&& (control_q[25] == control_q[24]))
		else $error("control ready bits out of step with enables");

	// Stored switch status always equals the switch field.
	a_cfg_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		config_q[3:2] == config_q[1:0])
		else $error("switch status out of step with switch field");

	// An access to the unmapped word yields zero read data.
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (idx == ccr_pkg::IDX_UNMAPPED)) |=> (m_tvalid && (m_tdata[31:0] == '0)))
		else $error("unmapped word returned non-zero data");

	// Input stalls only while a result is waiting.
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output register");
`endif

endmodule

// ----- tb/ccr_readback_checker.sv -----
// Checker for the clock-control register bank: predicts every readback and compares it.
`timescale 1ns / 1ps

module ccr_readback_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] write_data
	input  logic [3:0]   s_tuser,   // [0] opcode, [3:1] reg_index
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [143:0] m_tdata,   // [31:0] read_data, [58:32] sysclk_hz, [85:59] hclk_hz,
	                                // [112:86] pclk1_hz, [139:113] pclk2_hz, [143:140] zero
	output int unsigned  mismatches,
	output int unsigned  outstanding
);

	typedef struct packed {
		ccr_pkg::word_t rd;
		ccr_pkg::freq_t sys;
		ccr_pkg::freq_t hclk;
		ccr_pkg::freq_t pclk1;
		ccr_pkg::freq_t pclk2;
	} readback_t;

	// Shadow copy of the register bank.
	ccr_pkg::word_t ctl_q, cfg_q, irq_q, prst_q, fast_en_q, high_en_q, low_en_q;

	readback_t readbacks[$];
	readback_t got, want;

	function automatic int unsigned core_bus_shift(input logic [3:0] code);
		int unsigned s;
		case (code)
			4'd8:    s = 1;
			4'd9:    s = 2;
			4'd10:   s = 3;
			4'd11:   s = 4;
			4'd12:   s = 6;
			4'd13:   s = 7;
			4'd14:   s = 8;
			4'd15:   s = 9;
			default: s = 0;
		endcase
		return s;
	endfunction

	function automatic int unsigned periph_bus_shift(input logic [2:0] code);
		return (code[2]) ? int'(code[1:0]) + 1 : 0;
	endfunction

	task automatic apply_access(input logic op, input logic [2:0] idx,
		input ccr_pkg::word_t data);
		readback_t r;
		int unsigned sys_hz, hclk_hz, mul;
		logic wr;
		wr = (op == ccr_pkg::OP_WRITE);
		case (idx)
			ccr_pkg::IDX_CONTROL: begin
				if (wr)
					ctl_q = data;
				// Ready flags follow the HSI, HSE and PLL enables.
				ctl_q[1]  = ctl_q[0];
				ctl_q[17] = ctl_q[16];
				ctl_q[25] = ctl_q[24];
				r.rd = ctl_q;
			end
			ccr_pkg::IDX_CONFIG: begin
				if (wr)
					cfg_q = data;
				cfg_q[3:2] = cfg_q[1:0];
				r.rd = cfg_q;
			end
			ccr_pkg::IDX_IRQ: begin
				if (wr)
					irq_q = data;
				r.rd = irq_q;
			end
			ccr_pkg::IDX_PRST: begin
				if (wr)
					prst_q = data;
				r.rd = prst_q;
			end
			ccr_pkg::IDX_FAST_EN: begin
				if (wr)
					fast_en_q = data;
				r.rd = fast_en_q;
			end
			ccr_pkg::IDX_HIGH_EN: begin
				if (wr)
					high_en_q = data;
				r.rd = high_en_q;
			end
			ccr_pkg::IDX_LOW_EN: begin
				if (wr)
					low_en_q = data;
				r.rd = low_en_q;
			end
			default: r.rd = '0;
		endcase

		if (cfg_q[3:2] == ccr_pkg::SW_PLL) begin
			mul = (cfg_q[21:18] == ccr_pkg::PLL_MUL_MAX_CODE) ? 16 : int'(cfg_q[21:18]) + 2;
			sys_hz = (cfg_q[16] ? int'(ccr_pkg::HZ_8M) : int'(ccr_pkg::HZ_4M)) * mul;
		end else begin
			sys_hz = int'(ccr_pkg::HZ_8M);
		end
		hclk_hz = sys_hz >> core_bus_shift(cfg_q[7:4]);
		r.sys   = sys_hz[ccr_pkg::FREQ_W-1:0];
		r.hclk  = hclk_hz[ccr_pkg::FREQ_W-1:0];
		r.pclk1 = ccr_pkg::freq_t'(hclk_hz >> periph_bus_shift(cfg_q[10:8]));
		r.pclk2 = ccr_pkg::freq_t'(hclk_hz >> periph_bus_shift(cfg_q[13:11]));
		readbacks.push_back(r);
	endtask

	task automatic check_field(input string label, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected 0x%08h, got 0x%08h",
					$realtime, label, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       = ccr_pkg::CONTROL_RESET;
			cfg_q       = '0;
			irq_q       = '0;
			prst_q      = '0;
			fast_en_q   = '0;
			high_en_q   = '0;
			low_en_q    = '0;
			readbacks.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// Results leave before new accesses are predicted; they never belong to the same one.
			if (m_tvalid && m_tready) begin
				if (readbacks.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result item with nothing predicted: 0x%036h",
							$realtime, m_tdata);
				end else begin
					want = readbacks.pop_front();
					got.rd    = m_tdata[31:0];
					got.sys   = m_tdata[58:32];
					got.hclk  = m_tdata[85:59];
					got.pclk1 = m_tdata[112:86];
					got.pclk2 = m_tdata[139:113];
					check_field("read_data", want.rd, got.rd);
					check_field("sysclk_hz", 32'(want.sys), 32'(got.sys));
					check_field("hclk_hz", 32'(want.hclk), 32'(got.hclk));
					check_field("pclk1_hz", 32'(want.pclk1), 32'(got.pclk1));
					check_field("pclk2_hz", 32'(want.pclk2), 32'(got.pclk2));
					check_field("padding", 32'd0, 32'(m_tdata[143:140]));
				end
			end
			if (s_tvalid && s_tready)
				apply_access(s_tuser[0], s_tuser[3:1], s_tdata);
			outstanding = readbacks.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the register bank testbench: clock, reset, access stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;

	// Number of random accesses after the directed part, and how the run is shaped.
	localparam int RANDOM_ITEMS = 1930;
	localparam int CALM_ITEMS   = 150;	// the last accesses run with no idling at all
	localparam int SQUEEZE_AT   = 900;	// random access at which the long hold-off starts
	localparam int HOLD_OFF     = 60;	// cycles the receiver refuses results for
	// The limit is ten times an estimate of the slowest correct run.
	localparam int LIMIT_CYCLES = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;   // [31:0] write_data
	logic [3:0]   s_tuser;   // [0] opcode, [3:1] reg_index
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;   // [31:0] read_data, [58:32] sysclk_hz, [85:59] hclk_hz,
	                         // [112:86] pclk1_hz, [139:113] pclk2_hz, [143:140] zero

	int unsigned mismatches;
	int unsigned outstanding;

	// Shared between the sender and the receiver processes.
	bit calm;
	bit squeeze_now;
	int longest_hold;

	int cycle_count;
	int n_writes, n_reads, n_unmapped;

	clock_control_register_block dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ccr_readback_checker readback_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The watchdog ends a run that hangs; a correct run never gets near the limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results still awaited.",
			cycle_count, outstanding);
		$display("Regression FAIL");
		$finish;
	end

	// Idle cycles before the next item: mostly none, sometimes a burst of random length.
	// During the hold-off the sender keeps offering so that the block fills and stalls.
	function automatic int sender_gap();
		if (calm || squeeze_now)
			return 0;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
	endfunction

	// Offers one access item from a falling edge and waits until a rising edge takes it.
	// Each falling edge carries one assignment to s_tvalid at most, so a valid that stays
	// high for back-to-back items is never lowered and raised in the same step.
	task automatic push_access(input logic op, input logic [2:0] idx, input logic [31:0] data);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= {idx, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == ccr_pkg::OP_WRITE)
			n_writes++;
		else
			n_reads++;
		if (idx == ccr_pkg::IDX_UNMAPPED)
			n_unmapped++;
	endtask

	// Receiver: random stall bursts, one long hold-off on request, and no stalls once calm.
	initial begin
		int run;
		m_tready = 1'b0;
		longest_hold = 0;
		@(posedge arst_n);
		forever begin
			if (squeeze_now) begin
				@(negedge clk);
				m_tready <= 1'b0;
				for (run = 1; run < HOLD_OFF; run++)
					@(negedge clk);
				longest_hold = run;
				squeeze_now = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				run = $urandom_range(1, 9);
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (run - 1) @(negedge clk);
			end else begin
				@(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic        op;
		logic [2:0]  idx;
		logic [31:0] data;
		int          n;

		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		calm        = 1'b0;
		squeeze_now = 1'b0;
		n_writes    = 0;
		n_reads     = 0;
		n_unmapped  = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. First every word straight after reset, the unmapped one included.
		for (n = 0; n < 8; n++)
			push_access(ccr_pkg::OP_READ, 3'(n), 32'hFFFF_FFFF);

		// Control word: all ones, all zeros, then ready flags written against their enables.
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONTROL, 32'hFFFF_FFFF);
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONTROL, 32'h0000_0000);
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONTROL, 32'h0202_0002);
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONTROL, 32'h0101_0001);

		// Config word: PLL from the external source at the largest multiplier code, with the
		// switch status written wrongly; then the deepest prescalers on top of it.
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONFIG, 32'h003D_0006);
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONFIG, 32'h003D_3FF6);
		// PLL from the halved internal oscillator at the smallest and next-to-largest codes.
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONFIG, 32'h0000_0002);
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONFIG, 32'h0038_0002);
		// Switch codes three and one, the latter with the first divider step on every bus.
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONFIG, 32'h0000_0003);
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONFIG, 32'h0000_2481);
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONFIG, 32'hFFFF_FFFF);
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_CONFIG, 32'h0000_000C);

		// A write to the unmapped word is dropped and it still reads as zero.
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_UNMAPPED, 32'hFFFF_FFFF);
		push_access(ccr_pkg::OP_READ, ccr_pkg::IDX_UNMAPPED, 32'h0000_0000);

		// The peripheral reset word keeps what was written instead of clearing itself.
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_PRST, 32'hFFFF_FFFF);
		push_access(ccr_pkg::OP_READ, ccr_pkg::IDX_PRST, 32'h0000_0000);
		push_access(ccr_pkg::OP_WRITE, ccr_pkg::IDX_IRQ, 32'hA5A5_5A5A);

		// Random part. Five twelfths of the accesses go to the config word, and most config writes
		// select the PLL so that the multiplier and prescaler paths get plenty of traffic.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (n == SQUEEZE_AT)
				squeeze_now = 1'b1;
			op  = 1'($urandom_range(0, 1));
			idx = ($urandom_range(0, 2) == 0) ? ccr_pkg::IDX_CONFIG : 3'($urandom_range(0, 7));
			case ($urandom_range(0, 7))
				0:       data = 32'h0000_0000;
				1:       data = 32'hFFFF_FFFF;
				default: data = $urandom;
			endcase
			if (idx == ccr_pkg::IDX_CONFIG && $urandom_range(0, 3) != 0)
				data[1:0] = ccr_pkg::SW_PLL;
			push_access(op, idx, data);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain: everything predicted must arrive, then a few more cycles for stray results.
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		$display("Ran %0d accesses: %0d writes, %0d reads, %0d to the unmapped word.",
			n_writes + n_reads, n_writes, n_reads, n_unmapped);
		$display("Receiver held off once for %0d cycles; the last %0d accesses had no idling.",
			longest_hold, CALM_ITEMS);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d results never arrived.", mismatches, outstanding);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
